[src/gjr_pkg.sv]
// ----------------------------------------------------------------------------
// gjr_pkg
// Shared constants, types and helpers for the GJR-GARCH variance filter.
// ----------------------------------------------------------------------------
package gjr_pkg;

   localparam int DATA_W    = 32;
   localparam int COEF_W    = 16;
   localparam int OPND_W    = DATA_W + 1;
   localparam int PROD_W    = COEF_W + OPND_W;
   localparam int ACC_W     = 53;
   localparam int FRAC_SH   = 14;
   localparam int LANES     = 4;
   localparam int LANE_W    = 2;

   localparam int ARCH_MAX  = 4;
   localparam int GARCH_MAX = 4;
   localparam int EXOG_MAX  = 4;

   localparam int HIST_DEPTH = 4;
   localparam int HIST_AW    = 2;

   localparam logic [2:0] ARCH_LIM  = 3'((ARCH_MAX  < LANES) ? ARCH_MAX  : LANES);
   localparam logic [2:0] GARCH_LIM = 3'((GARCH_MAX < LANES) ? GARCH_MAX : LANES);
   localparam logic [2:0] EXOG_LIM  = 3'((EXOG_MAX  < LANES) ? EXOG_MAX  : LANES);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_COEFS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_COEFS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_COEFS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXOG_COEFS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCH_ORDER  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GARCH_ORDER = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_EXOG_COUNT  = 3'd7;

   // term groups, one per quarter of the tap sequence
   localparam logic [1:0] GRP_EXOG  = 2'd0;
   localparam logic [1:0] GRP_ALPHA = 2'd1;
   localparam logic [1:0] GRP_GAMMA = 2'd2;
   localparam logic [1:0] GRP_BETA  = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] neg_res;
      logic [DATA_W-1:0] var_h;
   } hist_word_type;

   function automatic logic signed [COEF_W-1:0] lane_coef(
      input logic [CSR_DATA_W-1:0] packed_coefs,
      input logic [LANE_W-1:0]     lane
   );
      logic [COEF_W-1:0] bits;
      bits = packed_coefs[lane*COEF_W +: COEF_W];
      return $signed(bits);
   endfunction

   function automatic logic [2:0] limit_order(
      input logic [2:0] order,
      input logic [2:0] cap
   );
      return (order > cap) ? cap : order;
   endfunction

endpackage

[src/gjr_if.sv]
// ----------------------------------------------------------------------------
// gjr_if
// Channel interfaces: step input, variance result and register write.
// ----------------------------------------------------------------------------
interface gjr_req_if;
   logic                              valid;
   logic                              ready;
   logic [gjr_pkg::DATA_W-1:0]        sq_residual;
   logic [gjr_pkg::DATA_W-1:0]        neg_sq_residual;
   logic signed [gjr_pkg::DATA_W-1:0] exog_0;
   logic signed [gjr_pkg::DATA_W-1:0] exog_1;
   logic signed [gjr_pkg::DATA_W-1:0] exog_2;
   logic signed [gjr_pkg::DATA_W-1:0] exog_3;
   logic                              preload;
   logic [gjr_pkg::DATA_W-1:0]        given_variance;

   modport source (output valid, sq_residual, neg_sq_residual, exog_0, exog_1, exog_2,
                   exog_3, preload, given_variance, input ready);
   modport sink   (input valid, sq_residual, neg_sq_residual, exog_0, exog_1, exog_2,
                   exog_3, preload, given_variance, output ready);
endinterface

interface gjr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gjr_pkg::DATA_W-1:0] variance;
   logic                       saturated;

   modport source (output valid, variance, saturated, input ready);
   modport sink   (input valid, variance, saturated, output ready);
endinterface

interface gjr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gjr_pkg::CSR_IDX_W-1:0]  index;
   logic [gjr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/gjr_garch_variance_filter.sv]
// ----------------------------------------------------------------------------
// gjr_garch_variance_filter
// GJR-GARCH(p,q) conditional variance filter over a four-entry history RAM.
// ----------------------------------------------------------------------------
// Sequence: a compute step issues 16 taps through one shared 16x33 multiplier,
//   drains the tap pipeline, then rounds into the result register; a preload
//   step loads its given variance; both wait while the result is held.
// Throughput: one step in flight; the next beat is taken the cycle after the
//   result loads.
// Reset: synchronous; registers take their reset values, history valid bits
//   clear so every history entry reads as zero until written.
// ----------------------------------------------------------------------------
module gjr_garch_variance_filter (
   input  logic       clock,
   input  logic       reset,
   gjr_req_if.sink    req_ch,
   gjr_rsp_if.source  rsp_ch,
   gjr_csr_if.sink    csr_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   localparam int DW = gjr_pkg::DATA_W;
   localparam int AW = gjr_pkg::ACC_W;
   localparam int PW = gjr_pkg::PROD_W;
   localparam int SH = gjr_pkg::FRAC_SH;

   // configuration
   logic signed [DW-1:0]                omega_ff;
   logic [gjr_pkg::CSR_DATA_W-1:0]      alpha_ff, gamma_ff, beta_ff, exogc_ff;
   logic [2:0]                          arch_ord_ff, garch_ord_ff, exog_cnt_ff;

   // control
   logic [1:0]                          state_ff, state_in;
   logic [3:0]                          cnt_ff;
   logic [gjr_pkg::HIST_AW-1:0]         wr_ptr_ff;
   logic [gjr_pkg::HIST_DEPTH-1:0]      hist_vld_ff;

   // latched step
   logic [DW-1:0]                       sq_ff, neg_ff, given_ff;
   logic signed [DW-1:0]                exog_ff [gjr_pkg::LANES];
   logic                                pre_ff;

   // tap pipeline
   logic                                a_vld_ff, p_vld_ff;
   logic signed [gjr_pkg::COEF_W-1:0]   a_coef_ff;
   logic [1:0]                          a_grp_ff;
   logic [gjr_pkg::LANE_W-1:0]          a_lane_ff;
   logic                                a_hv_ff;
   gjr_pkg::hist_word_type              rd_data_ff;
   logic signed [PW-1:0]                prod_ff;
   logic signed [AW-1:0]                acc_ff, acc_in;

   // history memory
   gjr_pkg::hist_word_type              hist_mem [gjr_pkg::HIST_DEPTH];

   // result
   logic                                rsp_valid_ff, rsp_sat_ff;
   logic [DW-1:0]                       rsp_var_ff;

   logic                                req_acc, rsp_load;
   logic [1:0]                          grp;
   logic [gjr_pkg::LANE_W-1:0]          lag;
   logic [gjr_pkg::HIST_AW-1:0]         rd_addr;
   logic                                tap_en;
   logic signed [gjr_pkg::COEF_W-1:0]   coef_sel;
   logic signed [gjr_pkg::OPND_W-1:0]   opnd;
   logic signed [AW-1:0]                rnd;
   logic [DW-1:0]                       res_var;
   logic                                res_sat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.variance  = rsp_var_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff     <= '0;
         alpha_ff     <= '0;
         gamma_ff     <= '0;
         beta_ff      <= '0;
         exogc_ff     <= '0;
         arch_ord_ff  <= 3'd1;
         garch_ord_ff <= 3'd1;
         exog_cnt_ff  <= 3'd0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            gjr_pkg::CSR_OMEGA:       omega_ff     <= $signed(csr_ch.data[DW-1:0]);
            gjr_pkg::CSR_ALPHA_COEFS: alpha_ff     <= csr_ch.data;
            gjr_pkg::CSR_GAMMA_COEFS: gamma_ff     <= csr_ch.data;
            gjr_pkg::CSR_BETA_COEFS:  beta_ff      <= csr_ch.data;
            gjr_pkg::CSR_EXOG_COEFS:  exogc_ff     <= csr_ch.data;
            gjr_pkg::CSR_ARCH_ORDER:  arch_ord_ff  <= csr_ch.data[2:0];
            gjr_pkg::CSR_GARCH_ORDER: garch_ord_ff <= csr_ch.data[2:0];
            gjr_pkg::CSR_EXOG_COUNT:  exog_cnt_ff  <= csr_ch.data[2:0];
            default: ;
         endcase
      end
   end

   // ---- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = req_ch.preload ? ST_FIN : ST_RUN;
         end
         ST_RUN: begin
            if (cnt_ff == 4'hF) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!a_vld_ff && !p_vld_ff) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RUN) cnt_ff <= cnt_ff + 4'd1;
         else                    cnt_ff <= '0;
      end
   end

   // step latch
   always_ff @(posedge clock) begin
      if (req_acc) begin
         sq_ff      <= req_ch.sq_residual;
         neg_ff     <= req_ch.neg_sq_residual;
         given_ff   <= req_ch.given_variance;
         pre_ff     <= req_ch.preload;
         exog_ff[0] <= req_ch.exog_0;
         exog_ff[1] <= req_ch.exog_1;
         exog_ff[2] <= req_ch.exog_2;
         exog_ff[3] <= req_ch.exog_3;
      end
   end

   // ---- tap issue: counter high bits pick the term group, low bits the lag
   assign grp     = cnt_ff[3:2];
   assign lag     = cnt_ff[1:0];
   assign rd_addr = wr_ptr_ff - gjr_pkg::HIST_AW'(1) - lag;

   always_comb begin
      case (grp)
         gjr_pkg::GRP_EXOG: begin
            coef_sel = gjr_pkg::lane_coef(exogc_ff, lag);
            tap_en   = {1'b0, lag} < gjr_pkg::limit_order(exog_cnt_ff, gjr_pkg::EXOG_LIM);
         end
         gjr_pkg::GRP_ALPHA: begin
            coef_sel = gjr_pkg::lane_coef(alpha_ff, lag);
            tap_en   = {1'b0, lag} < gjr_pkg::limit_order(arch_ord_ff, gjr_pkg::ARCH_LIM);
         end
         gjr_pkg::GRP_GAMMA: begin
            coef_sel = gjr_pkg::lane_coef(gamma_ff, lag);
            tap_en   = {1'b0, lag} < gjr_pkg::limit_order(arch_ord_ff, gjr_pkg::ARCH_LIM);
         end
         default: begin
            coef_sel = gjr_pkg::lane_coef(beta_ff, lag);
            tap_en   = {1'b0, lag} < gjr_pkg::limit_order(garch_ord_ff, gjr_pkg::GARCH_LIM);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= (state_ff == ST_RUN);
         p_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_coef_ff <= tap_en ? coef_sel : '0;
      a_grp_ff  <= grp;
      a_lane_ff <= lag;
      a_hv_ff   <= hist_vld_ff[rd_addr];
   end

   // ---- history RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (rsp_load) hist_mem[wr_ptr_ff] <= '{res: sq_ff, neg_res: neg_ff, var_h: res_var};
      rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         hist_vld_ff <= '0;
      end else if (rsp_load) begin
         wr_ptr_ff              <= wr_ptr_ff + gjr_pkg::HIST_AW'(1);
         hist_vld_ff[wr_ptr_ff] <= 1'b1;
      end
   end

   // ---- multiply
   always_comb begin
      case (a_grp_ff)
         gjr_pkg::GRP_EXOG:  opnd = {exog_ff[a_lane_ff][DW-1], exog_ff[a_lane_ff]};
         gjr_pkg::GRP_ALPHA: opnd = a_hv_ff ? $signed({1'b0, rd_data_ff.res})     : '0;
         gjr_pkg::GRP_GAMMA: opnd = a_hv_ff ? $signed({1'b0, rd_data_ff.neg_res}) : '0;
         default:            opnd = a_hv_ff ? $signed({1'b0, rd_data_ff.var_h})   : '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_coef_ff * opnd;
   end

   // ---- accumulate
   always_comb begin
      acc_in = acc_ff;
      if (req_acc) begin
         acc_in = {{(AW-DW-SH){omega_ff[DW-1]}}, omega_ff, {SH{1'b0}}};
      end else if (p_vld_ff) begin
         acc_in = acc_ff + {{(AW-PW){prod_ff[PW-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // ---- round and clamp
   assign rnd = acc_ff + AW'(1 << (SH - 1));

   always_comb begin
      if (pre_ff) begin
         res_var = given_ff;
         res_sat = 1'b0;
      end else if (rnd[AW-1]) begin
         res_var = '0;
         res_sat = 1'b1;
      end else if (rnd[AW-2:DW+SH] != '0) begin
         res_var = '1;
         res_sat = 1'b1;
      end else begin
         res_var = rnd[DW+SH-1:SH];
         res_sat = 1'b0;
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_var_ff <= res_var;
         rsp_sat_ff <= res_sat;
      end
   end

   // ---- checks
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> (rsp_var_ff == '0) || (rsp_var_ff == '1))
      else $error("saturated result not at a range limit");

   a_pipe_in_run: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> (state_ff == ST_RUN) || (state_ff == ST_WAIT))
      else $error("product valid outside tap sequence");

   a_hist_written: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> hist_vld_ff[$past(wr_ptr_ff)] && rsp_valid_ff)
      else $error("history entry not marked after result load");

   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_ch.preload |=> (state_ff == ST_RUN) && (cnt_ff == 4'd0))
      else $error("compute beat did not start tap sequence");

endmodule
